>>> rtl/ssr_pkg.sv
// Package with shared types and constants for the Shamir secret reconstruction block.
`default_nettype none
package ssr_pkg;
   localparam int MAX_SHARES = 16;
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;
   localparam logic [31:0] FIELD_P = 32'hFFFF_FFFB;
   localparam logic [31:0] EXP_INV = 32'hFFFF_FFF9;
   localparam logic [4:0] THRESHOLD_RESET = 5'd2;

   typedef struct packed {
      logic [31:0] share_x;
      logic [31:0] share_y;
      logic        last_share;
   } req_type;

   typedef struct packed {
      logic [31:0] secret;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic             wr;
      logic             last;
      logic             short_set;
      logic [IDX_W-1:0] addr;
      logic [CNT_W-1:0] k;
      logic [31:0]      x;
      logic [31:0]      y;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_J, ST_LAT_J, ST_RD_M, ST_LAT_M, ST_NUM_S, ST_NUM_W,
      ST_DEN_S, ST_DEN_W, ST_INR_S, ST_INR_W, ST_INB_S, ST_INB_W,
      ST_T1_S, ST_T1_W, ST_T2_S, ST_T2_W, ST_ACC, ST_OUT
   } back_state_type;
endpackage
`default_nettype wire

>>> rtl/ssr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/ssr_mulmod.sv
// Three-stage modular multiplier for the prime 2^32 - 5.
`default_nettype none
module ssr_mulmod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic             done,
   output logic      [31:0] result
);
   logic [63:0] prod_ff;
   logic [35:0] fold_ff;
   logic [35:0] fold_in;
   logic [32:0] sum_in;
   logic [31:0] res_ff;
   logic [31:0] res_in;
   logic [2:0]  vld_ff;

   always_comb begin
      fold_in = 36'({prod_ff[63:32], 2'b00}) + 36'(prod_ff[63:32]) + 36'(prod_ff[31:0]);
      sum_in  = 33'(fold_ff[31:0]) + 33'({fold_ff[35:32], 2'b00}) + 33'(fold_ff[35:32]);
      res_in  = (sum_in >= 33'(ssr_pkg::FIELD_P)) ? 32'(sum_in - 33'(ssr_pkg::FIELD_P))
                                                  : sum_in[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(a) * 64'(b);
      fold_ff <= fold_in;
      res_ff  <= res_in;
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
   end

   assign done   = vld_ff[2];
   assign result = res_ff;
endmodule
`default_nettype wire

>>> rtl/ssr_front.sv
// Front end: takes share beats, reduces them, tracks the set and issues commands.
`default_nettype none
module ssr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ssr_pkg::req_type req_data,
   output logic                  full,
   input  wire logic             csr_valid,
   input  wire logic [4:0]       csr_data,
   output logic                  csr_ready,
   input  wire logic             fifo_full,
   output logic                  cmd_push,
   output ssr_pkg::cmd_type      cmd_data
);
   logic [4:0] threshold_ff;
   logic [4:0] threshold_in;
   logic [ssr_pkg::CNT_W-1:0] count_ff;
   logic [ssr_pkg::CNT_W-1:0] count_in;
   logic [ssr_pkg::CNT_W-1:0] k;
   logic [ssr_pkg::CNT_W-1:0] count_after;
   logic accept;
   logic keep;

   always_comb begin
      k = (threshold_ff > 5'(ssr_pkg::MAX_SHARES)) ? 5'(ssr_pkg::MAX_SHARES) : threshold_ff;
      accept = push && !fifo_full;
      keep = count_ff < k;
      count_after = keep ? count_ff + 5'd1 : count_ff;
      threshold_in = (csr_valid) ? csr_data : threshold_ff;
      count_in = count_ff;
      if (accept) begin
         count_in = req_data.last_share ? '0 : count_after;
      end
      cmd_data.wr = keep;
      cmd_data.last = req_data.last_share;
      cmd_data.short_set = count_after < k;
      cmd_data.addr = count_ff[ssr_pkg::IDX_W-1:0];
      cmd_data.k = k;
      cmd_data.x = (req_data.share_x >= ssr_pkg::FIELD_P) ?
                   req_data.share_x - ssr_pkg::FIELD_P : req_data.share_x;
      cmd_data.y = (req_data.share_y >= ssr_pkg::FIELD_P) ?
                   req_data.share_y - ssr_pkg::FIELD_P : req_data.share_y;
      cmd_push = accept && (keep || req_data.last_share);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ssr_pkg::THRESHOLD_RESET;
         count_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         count_ff <= count_in;
      end
   end

   assign full = fifo_full;
   assign csr_ready = 1'b1;
endmodule
`default_nettype wire

>>> rtl/ssr_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module ssr_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ssr_pkg::cmd_type push_data,
   input  wire logic             pop,
   output ssr_pkg::cmd_type      head,
   output logic                  full,
   output logic                  empty
);
   ssr_pkg::cmd_type entries_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign head = entries_ff[rptr_ff];
   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
endmodule
`default_nettype wire

>>> rtl/ssr_back.sv
// Back end: stores shares and runs the Lagrange interpolation sequencer.
`default_nettype none
module ssr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ssr_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output logic                  empty,
   input  wire logic             pop,
   output ssr_pkg::rsp_type      rsp_data
);
   ssr_pkg::back_state_type state_ff, state_in;
   logic [ssr_pkg::IDX_W-1:0] j_ff, j_in, m_ff, m_in, rd_addr, km1;
   logic [ssr_pkg::CNT_W-1:0] k_ff, k_in, bit_ff, bit_in;
   logic [31:0] xj_ff, xj_in, yj_ff, yj_in, xm_ff, xm_in;
   logic [31:0] num_ff, num_in, den_ff, den_in, base_ff, base_in;
   logic [31:0] r_ff, r_in, t_ff, t_in, acc_ff, acc_in;
   ssr_pkg::rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rd_x, rd_y, diff, mul_a, mul_b, mul_res;
   logic [32:0] acc_sum;
   logic mul_start, mul_done, ebit;

   ssr_ram #(.WIDTH(32), .DEPTH(ssr_pkg::MAX_SHARES)) u_ram_x (
      .clock(clock), .wr_en(cmd_pop && cmd.wr), .wr_addr(cmd.addr), .wr_data(cmd.x),
      .rd_addr(rd_addr), .rd_data(rd_x));

   ssr_ram #(.WIDTH(32), .DEPTH(ssr_pkg::MAX_SHARES)) u_ram_y (
      .clock(clock), .wr_en(cmd_pop && cmd.wr), .wr_addr(cmd.addr), .wr_data(cmd.y),
      .rd_addr(rd_addr), .rd_data(rd_y));

   ssr_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .result(mul_res));

   always_comb begin
      km1 = k_ff[ssr_pkg::IDX_W-1:0] - 1'b1;
      diff = xm_ff - xj_ff + ((xm_ff < xj_ff) ? ssr_pkg::FIELD_P : 32'd0);
      ebit = ssr_pkg::EXP_INV[bit_ff];
      acc_sum = 33'(acc_ff) + 33'(mul_res);
      rd_addr = (state_ff == ssr_pkg::ST_RD_M) ? m_ff : j_ff;

      state_in = state_ff;
      j_in = j_ff; m_in = m_ff; k_in = k_ff; bit_in = bit_ff;
      xj_in = xj_ff; yj_in = yj_ff; xm_in = xm_ff;
      num_in = num_ff; den_in = den_ff; base_in = base_ff;
      r_in = r_ff; t_in = t_ff; acc_in = acc_ff; res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      cmd_pop = 1'b0;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;

      case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.last) begin
                  res_in.secret = '0;
                  res_in.status = cmd.short_set;
                  k_in = cmd.k;
                  j_in = '0;
                  acc_in = '0;
                  if (cmd.short_set || cmd.k == '0) begin
                     state_in = ssr_pkg::ST_OUT;
                  end else begin
                     state_in = ssr_pkg::ST_RD_J;
                  end
               end
            end
         end
         ssr_pkg::ST_RD_J: state_in = ssr_pkg::ST_LAT_J;
         ssr_pkg::ST_LAT_J: begin
            xj_in = rd_x;
            yj_in = rd_y;
            num_in = 32'd1;
            den_in = 32'd1;
            m_in = '0;
            state_in = ssr_pkg::ST_RD_M;
         end
         ssr_pkg::ST_RD_M: state_in = ssr_pkg::ST_LAT_M;
         ssr_pkg::ST_LAT_M: begin
            xm_in = rd_x;
            if (m_ff != j_ff) begin
               state_in = ssr_pkg::ST_NUM_S;
            end else if (m_ff == km1) begin
               base_in = den_ff;
               r_in = 32'd1;
               bit_in = '0;
               state_in = ssr_pkg::ST_INR_S;
            end else begin
               m_in = m_ff + 1'b1;
               state_in = ssr_pkg::ST_RD_M;
            end
         end
         ssr_pkg::ST_NUM_S: begin
            mul_start = 1'b1;
            mul_a = num_ff;
            mul_b = xm_ff;
            state_in = ssr_pkg::ST_NUM_W;
         end
         ssr_pkg::ST_NUM_W: begin
            if (mul_done) begin
               num_in = mul_res;
               state_in = ssr_pkg::ST_DEN_S;
            end
         end
         ssr_pkg::ST_DEN_S: begin
            mul_start = 1'b1;
            mul_a = den_ff;
            mul_b = diff;
            state_in = ssr_pkg::ST_DEN_W;
         end
         ssr_pkg::ST_DEN_W: begin
            if (mul_done) begin
               if (m_ff == km1) begin
                  base_in = mul_res;
                  r_in = 32'd1;
                  bit_in = '0;
                  state_in = ssr_pkg::ST_INR_S;
               end else begin
                  den_in = mul_res;
                  m_in = m_ff + 1'b1;
                  state_in = ssr_pkg::ST_RD_M;
               end
            end
         end
         ssr_pkg::ST_INR_S: begin
            if (ebit) begin
               mul_start = 1'b1;
               mul_a = r_ff;
               mul_b = base_ff;
               state_in = ssr_pkg::ST_INR_W;
            end else begin
               state_in = ssr_pkg::ST_INB_S;
            end
         end
         ssr_pkg::ST_INR_W: begin
            if (mul_done) begin
               r_in = mul_res;
               state_in = ssr_pkg::ST_INB_S;
            end
         end
         ssr_pkg::ST_INB_S: begin
            mul_start = 1'b1;
            mul_a = base_ff;
            mul_b = base_ff;
            state_in = ssr_pkg::ST_INB_W;
         end
         ssr_pkg::ST_INB_W: begin
            if (mul_done) begin
               base_in = mul_res;
               if (bit_ff == 5'd31) begin
                  state_in = ssr_pkg::ST_T1_S;
               end else begin
                  bit_in = bit_ff + 5'd1;
                  state_in = ssr_pkg::ST_INR_S;
               end
            end
         end
         ssr_pkg::ST_T1_S: begin
            mul_start = 1'b1;
            mul_a = yj_ff;
            mul_b = num_ff;
            state_in = ssr_pkg::ST_T1_W;
         end
         ssr_pkg::ST_T1_W: begin
            if (mul_done) begin
               t_in = mul_res;
               state_in = ssr_pkg::ST_T2_S;
            end
         end
         ssr_pkg::ST_T2_S: begin
            mul_start = 1'b1;
            mul_a = t_ff;
            mul_b = r_ff;
            state_in = ssr_pkg::ST_T2_W;
         end
         ssr_pkg::ST_T2_W: begin
            if (mul_done) begin
               state_in = ssr_pkg::ST_ACC;
               acc_in = (acc_sum >= 33'(ssr_pkg::FIELD_P)) ?
                        32'(acc_sum - 33'(ssr_pkg::FIELD_P)) : acc_sum[31:0];
            end
         end
         ssr_pkg::ST_ACC: begin
            if (j_ff == km1) begin
               res_in.secret = acc_ff;
               res_in.status = 1'b0;
               state_in = ssr_pkg::ST_OUT;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = ssr_pkg::ST_RD_J;
            end
         end
         ssr_pkg::ST_OUT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ssr_pkg::ST_IDLE;
            end
         end
         default: state_in = ssr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      j_ff <= j_in; m_ff <= m_in; k_ff <= k_in; bit_ff <= bit_in;
      xj_ff <= xj_in; yj_ff <= yj_in; xm_ff <= xm_in;
      num_ff <= num_in; den_ff <= den_in; base_ff <= base_in;
      r_ff <= r_in; t_ff <= t_in; acc_ff <= acc_in;
      res_ff <= res_in; rsp_ff <= rsp_in;
   end

   assign empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/shamir_secret_reconstruction.sv
// Top level of the Shamir secret reconstruction block over the field mod 2^32 - 5.
// Shares are taken one beat per cycle while the command queue is not full; the queue holds
// two entries, and the back end stores each share from its idle state. A beat with
// last_share set runs Lagrange interpolation at zero on a single shared modular multiplier,
// which sets the time: with k the effective threshold, reconstruction is dominated by one
// Fermat inversion of 32 squarings and 30 multiplications per share. The threshold register
// resets to 2 and the effective threshold saturates at 16. A short set returns status 1 and
// secret 0. The result waits in an output register while the next shares are accepted.
`default_nettype none
module shamir_secret_reconstruction (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ssr_pkg::req_type req_data,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output ssr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [4:0]       csr_data
);
   ssr_pkg::cmd_type cmd_in_data;
   ssr_pkg::cmd_type cmd_head;
   logic cmd_push, cmd_pop, cmd_full, cmd_empty;

   ssr_front u_front (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data), .full(full),
      .csr_valid(csr_valid), .csr_data(csr_data), .csr_ready(csr_ready),
      .fifo_full(cmd_full), .cmd_push(cmd_push), .cmd_data(cmd_in_data));

   ssr_cmd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(cmd_push), .push_data(cmd_in_data),
      .pop(cmd_pop), .head(cmd_head), .full(cmd_full), .empty(cmd_empty));

   ssr_back u_back (
      .clock(clock), .reset(reset), .cmd(cmd_head), .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop), .empty(empty), .pop(pop), .rsp_data(rsp_data));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && cmd_full)) else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty) else $error("command queue underflow");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status) |-> rsp_data.secret == 32'd0)
      else $error("error result carries a nonzero secret");
   a_in_field: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.secret < ssr_pkg::FIELD_P) else $error("secret not reduced");
endmodule
`default_nettype wire

>>> sim/shamir_secret_reconstruction_tb.sv
// Testbench for the Shamir secret reconstruction block: directed and random share sets checked against a field-arithmetic predictor.
`timescale 1ns / 1ps
module shamir_secret_reconstruction_tb;
   localparam logic [63:0] PRIME = 64'd4294967291;
   localparam int CYCLE_LIMIT = 12000000;
   localparam int EXPECT_DEPTH = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   ssr_pkg::req_type req_data = '0;
   logic full;
   logic empty;
   logic pop = 1'b0;
   ssr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;

   shamir_secret_reconstruction DUT (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data), .full(full),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   logic [31:0] kept_x [ssr_pkg::MAX_SHARES];
   logic [31:0] kept_y [ssr_pkg::MAX_SHARES];
   int kept_count = 0;
   logic [4:0] share_threshold = ssr_pkg::THRESHOLD_RESET;
   ssr_pkg::rsp_type expected_buf [EXPECT_DEPTH];
   int expected_head = 0;
   int expected_tail = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   bit sender_done = 1'b0;

   function automatic logic [31:0] field_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] wide;
      wide = 64'(a) * 64'(b);
      return 32'(wide % PRIME);
   endfunction

   function automatic logic [31:0] field_inv(logic [31:0] a);
      logic [31:0] acc;
      logic [31:0] base;
      logic [31:0] power;
      acc = 32'd1;
      base = a;
      power = ssr_pkg::EXP_INV;
      while (power != 0) begin
         if (power[0]) acc = field_mul(acc, base);
         base = field_mul(base, base);
         power = power >> 1;
      end
      return acc;
   endfunction

   function automatic logic [31:0] lagrange_at_zero(int k);
      logic [63:0] total;
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] diff;
      total = 0;
      for (int j = 0; j < k; j++) begin
         num = 32'd1;
         den = 32'd1;
         for (int m = 0; m < k; m++) begin
            if (m != j) begin
               num = field_mul(num, kept_x[m]);
               diff = (kept_x[m] >= kept_x[j]) ? kept_x[m] - kept_x[j]
                                                : 32'(64'(kept_x[m]) + PRIME - 64'(kept_x[j]));
               den = field_mul(den, diff);
            end
         end
         total = (total + 64'(field_mul(field_mul(kept_y[j], num), field_inv(den)))) % PRIME;
      end
      return 32'(total);
   endfunction

   // Returns 1 with the expected result when the share closes a set.
   function automatic bit predict_share(ssr_pkg::req_type r, output ssr_pkg::rsp_type res);
      int k;
      logic [31:0] x;
      logic [31:0] y;
      k = (share_threshold > ssr_pkg::MAX_SHARES) ? ssr_pkg::MAX_SHARES
                                                  : int'(share_threshold);
      x = 32'(64'(r.share_x) % PRIME);
      y = 32'(64'(r.share_y) % PRIME);
      res = '0;
      if (kept_count < k) begin
         kept_x[kept_count] = x;
         kept_y[kept_count] = y;
         kept_count++;
      end
      if (!r.last_share) return 1'b0;
      if (kept_count < k) begin
         res.secret = '0;
         res.status = 1'b1;
      end else begin
         res.secret = lagrange_at_zero(k);
         res.status = 1'b0;
      end
      kept_count = 0;
      return 1'b1;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   task automatic send_share(ssr_pkg::req_type r, bit check_typed, ssr_pkg::rsp_type typed);
      ssr_pkg::rsp_type res;
      int gap;
      gap = $urandom_range(0, 13);
      if (gap != 0) begin
         push <= 1'b0;
         idle_cycles(gap);
      end
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      if (predict_share(r, res)) begin
         if (check_typed && res != typed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Typed result %h/%b disagrees with predictor %h/%b",
                        typed.secret, typed.status, res.secret, res.status);
         end
         expected_buf[expected_tail % EXPECT_DEPTH] = res;
         expected_tail++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_tail != expected_head) @(negedge clock);
      idle_cycles(4000);
   endtask

   task automatic write_threshold(logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      share_threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
         2: return 32'hFFFF_FFFA;
         default: return $urandom;
      endcase
   endfunction

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      bit last;
      bit typed;
      ssr_pkg::rsp_type result;
   } stim_row_type;

   stim_row_type directed_rows [] = '{
      '{32'd1, 32'd5, 1'b1, 1'b1, '{32'd0, 1'b1}},
      '{32'd1, 32'd7, 1'b0, 1'b0, '{32'd0, 1'b0}},
      '{32'd2, 32'd9, 1'b1, 1'b0, '{32'd0, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '{32'd0, 1'b0}},
      '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b1, 1'b0, '{32'd0, 1'b0}},
      '{32'd3, 32'd4, 1'b0, 1'b0, '{32'd0, 1'b0}},
      '{32'd3, 32'd8, 1'b0, 1'b0, '{32'd0, 1'b0}},
      '{32'd6, 32'd1, 1'b1, 1'b0, '{32'd0, 1'b0}},
      '{32'd0, 32'd0, 1'b0, 1'b0, '{32'd0, 1'b0}},
      '{32'd0, 32'hAAAA_5555, 1'b1, 1'b0, '{32'd0, 1'b0}}
   };

   initial begin
      ssr_pkg::rsp_type dummy;
      int k;
      int phase_thresholds [] = '{1, 16, 31, 0, 3, 5, 8, 2};
      dummy = '0;
      idle_cycles(4);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_share('{directed_rows[i].x, directed_rows[i].y, directed_rows[i].last},
                    directed_rows[i].typed, directed_rows[i].result);
      wait_drained();
      foreach (phase_thresholds[p]) begin
         write_threshold(5'(phase_thresholds[p]));
         for (int n = 0; n < 220; n++) begin
            k = (share_threshold > ssr_pkg::MAX_SHARES) ? ssr_pkg::MAX_SHARES
                                                        : int'(share_threshold);
            if (k > 6 && $urandom_range(0, 3) != 0) k = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) k = $urandom_range(0, k + 2);
            else if (k >= 1) k = k + $urandom_range(0, 1) - 1 + (share_threshold == 0 ? 1 : 1);
            if (k < 1) k = 1;
            for (int s = 0; s < k - 1; s++)
               send_share('{rand_field(), rand_field(), 1'b0}, 1'b0, dummy);
            send_share('{rand_field(), rand_field(), 1'b1}, 1'b0, dummy);
            n += k - 1;
            if (n == 100) wait_drained();
         end
         wait_drained();
      end
      sender_done = 1'b1;
   end

   initial begin
      ssr_pkg::rsp_type want;
      int gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 13);
         if (gap != 0) begin
            pop <= 1'b0;
            idle_cycles(gap);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (expected_tail == expected_head) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result beat %h/%b", rsp_data.secret, rsp_data.status);
         end else begin
            want = expected_buf[expected_head % EXPECT_DEPTH];
            expected_head++;
            if (rsp_data.secret !== want.secret || rsp_data.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result beat mismatch: expected %h/%b, got %h/%b",
                           want.secret, want.status, rsp_data.secret, rsp_data.status);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (sender_done) begin
         if (mismatch_count == 0 && expected_tail == expected_head)
            $display("shamir_secret_reconstruction_tb passed");
         else
            $display("shamir_secret_reconstruction_tb failed");
         $finish;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("shamir_secret_reconstruction_tb failed");
         $finish;
      end
   end
endmodule
